[rtl/nmea_pkg.sv]
package nmea_pkg;

    localparam int unsigned MAX_LEN_DEF = 255;
    localparam int unsigned TYPE_CHARS = 5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_A = 8'h41;

    localparam logic [8*TYPE_CHARS-1:0] GGA_NAME = "GPGGA";
    localparam logic [8*TYPE_CHARS-1:0] RMC_NAME = "GPRMC";

    localparam logic [4:0] GGA_COUNT = 5'd13;
    localparam logic [4:0] RMC_COUNT = 5'd10;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SKIP   = 3'd1,
        PH_FIELDS = 3'd2,
        PH_HEX    = 3'd3,
        PH_TAIL   = 3'd4,
        PH_LONG   = 3'd5
    } phase_t;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_GGA = 2'd1;
    localparam logic [1:0] KIND_RMC = 2'd2;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_NO_DOLLAR = 3'd1;
    localparam logic [2:0] ERR_NO_STAR = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;
    localparam logic [2:0] ERR_FIELD_LONG = 3'd5;
    localparam logic [2:0] ERR_UNKNOWN = 3'd6;
    localparam logic [2:0] ERR_MISSING = 3'd7;

    localparam logic [4:0] FID_STATUS = 5'd2;
    localparam logic [4:0] FID_FIXQ = 5'd7;

    // field id for the n-th field of a sentence kind
    function automatic logic [4:0] field_id_of(input logic [1:0] kind, input logic [4:0] fn);
        logic [4:0] id;
        id = 5'd0;
        if (kind == KIND_RMC) begin
            case (fn)
                5'd0: id = 5'd0;
                5'd1: id = 5'd1;
                5'd2: id = 5'd2;
                5'd3: id = 5'd3;
                5'd4: id = 5'd4;
                5'd5: id = 5'd5;
                5'd6: id = 5'd6;
                5'd7: id = 5'd14;
                5'd8: id = 5'd15;
                5'd9: id = 5'd16;
                default: id = 5'd0;
            endcase
        end
        else begin
            case (fn)
                5'd0: id = 5'd0;
                5'd1: id = 5'd1;
                5'd2: id = 5'd3;
                5'd3: id = 5'd4;
                5'd4: id = 5'd5;
                5'd5: id = 5'd6;
                5'd6: id = 5'd7;
                5'd7: id = 5'd8;
                5'd8: id = 5'd9;
                5'd9: id = 5'd10;
                5'd10: id = 5'd11;
                5'd11: id = 5'd12;
                5'd12: id = 5'd13;
                default: id = 5'd0;
            endcase
        end
        return id;
    endfunction

    // character limit for the n-th field of a sentence kind
    function automatic logic [3:0] field_lim_of(input logic [1:0] kind, input logic [4:0] fn);
        logic [3:0] lim;
        lim = 4'd0;
        if (kind == KIND_RMC) begin
            case (fn)
                5'd0: lim = 4'd6;
                5'd1: lim = 4'd11;
                5'd2: lim = 4'd2;
                5'd3: lim = 4'd10;
                5'd4: lim = 4'd2;
                5'd5: lim = 4'd11;
                5'd6: lim = 4'd2;
                5'd7: lim = 4'd8;
                5'd8: lim = 4'd8;
                5'd9: lim = 4'd8;
                default: lim = 4'd0;
            endcase
        end
        else begin
            case (fn)
                5'd0: lim = 4'd6;
                5'd1: lim = 4'd11;
                5'd2: lim = 4'd10;
                5'd3: lim = 4'd2;
                5'd4: lim = 4'd11;
                5'd5: lim = 4'd2;
                5'd6: lim = 4'd2;
                5'd7: lim = 4'd3;
                5'd8: lim = 4'd6;
                5'd9: lim = 4'd8;
                5'd10: lim = 4'd2;
                5'd11: lim = 4'd8;
                5'd12: lim = 4'd2;
                default: lim = 4'd0;
            endcase
        end
        return lim;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = CH_ZERO + {4'd0, n};
        end
        else begin
            c = CH_A + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

endpackage

[rtl/nmea_sentence_parser_top.sv]
// nmea sentence parser, gga and rmc
// input channel s_axis: one sentence byte per word, tlast marks the final byte of
// the buffered sentence. output channel m_axis: tuser 0 gives a field character
// (field id, position, byte), tuser 1 gives the sentence verdict (error code,
// kind, fix valid). a byte yields at most one word; the last byte always yields
// the verdict and its own field character is dropped.
// a result is registered and appears on m_axis in the cycle after its byte is taken.
// throughput: one byte per cycle unless m_axis stalls; all parsing is one step
// of combinational logic from the parse state into the output register.
// the output register holds its word while m_axis_tready is low, and a new byte
// is taken in the same cycle the held word leaves, so a stalled receiver holds
// back s_axis_tready only while the register is full.
// reset clears the parse state to await the first byte of a new sentence and
// empties the output register.
module nmea_sentence_parser_top #(
    parameter int unsigned MAX_LEN = nmea_pkg::MAX_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [4:0] field_id, [8:5] char_position,
                                       // [16:9] char_value, [19:17] error_code,
                                       // [21:20] sentence_kind, [22] fix_valid
    output logic        m_axis_tuser   // result_type
);

    nmea_pkg::phase_t phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [4:0] field_num_reg, field_num_next;
    logic [3:0] char_cnt_reg, char_cnt_next;
    logic [7:0] type_reg [nmea_pkg::TYPE_CHARS];
    logic [7:0] type_next [nmea_pkg::TYPE_CHARS];
    logic [1:0] kind_reg, kind_next;
    logic [2:0] first_err_reg, first_err_next;
    logic [7:0] fix_char_reg, fix_char_next;
    logic [1:0] hex_seen_reg, hex_seen_next;
    logic       csum_ok_reg, csum_ok_next;
    logic [7:0] byte_cnt_reg, byte_cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_user_reg, out_user_next;
    logic [23:0] out_data_reg, out_data_next;

    logic       accept;
    logic [7:0] b;
    logic       emit;
    logic [4:0] fid;
    logic [3:0] lim;
    logic [4:0] count;
    logic [2:0] code;
    logic       fix;
    logic       is_gga;
    logic       is_rmc;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign b = s_axis_tdata;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_user_reg;
    assign m_axis_tdata = out_data_reg;

    always_comb
    begin
        phase_next = phase_reg;
        xor_next = xor_reg;
        field_num_next = field_num_reg;
        char_cnt_next = char_cnt_reg;
        for (int k = 0; k < nmea_pkg::TYPE_CHARS; k++)
        begin
            type_next[k] = type_reg[k];
        end
        kind_next = kind_reg;
        first_err_next = first_err_reg;
        fix_char_next = fix_char_reg;
        hex_seen_next = hex_seen_reg;
        csum_ok_next = csum_ok_reg;
        byte_cnt_next = byte_cnt_reg;
        emit = 1'b0;
        code = nmea_pkg::ERR_OK;
        fix = 1'b0;

        count = (kind_reg == nmea_pkg::KIND_RMC) ? nmea_pkg::RMC_COUNT : nmea_pkg::GGA_COUNT;
        fid = nmea_pkg::field_id_of(kind_reg, field_num_reg);
        lim = nmea_pkg::field_lim_of(kind_reg, field_num_reg);

        is_gga = (char_cnt_reg >= 4'(nmea_pkg::TYPE_CHARS));
        is_rmc = is_gga;
        for (int k = 0; k < nmea_pkg::TYPE_CHARS; k++)
        begin
            if (type_reg[k] != nmea_pkg::GGA_NAME[8*(nmea_pkg::TYPE_CHARS-1-k) +: 8])
            begin
                is_gga = 1'b0;
            end
            if (type_reg[k] != nmea_pkg::RMC_NAME[8*(nmea_pkg::TYPE_CHARS-1-k) +: 8])
            begin
                is_rmc = 1'b0;
            end
        end

        if (phase_reg == nmea_pkg::PH_IDLE)
        begin
            // state already holds reset values here
            byte_cnt_next = 8'd1;
            phase_next = (b == nmea_pkg::CH_DOLLAR) ? nmea_pkg::PH_FIELDS : nmea_pkg::PH_SKIP;
        end
        else if (phase_reg != nmea_pkg::PH_SKIP && phase_reg != nmea_pkg::PH_LONG)
        begin
            if (byte_cnt_reg >= 8'(MAX_LEN))
            begin
                phase_next = nmea_pkg::PH_LONG;
            end
            else
            begin
                byte_cnt_next = byte_cnt_reg + 8'd1;
                case (phase_reg)
                    nmea_pkg::PH_FIELDS:
                    begin
                        if (b == nmea_pkg::CH_STAR)
                        begin
                            phase_next = nmea_pkg::PH_HEX;
                            hex_seen_next = 2'd0;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ b;
                            if (first_err_reg == nmea_pkg::ERR_OK && field_num_reg < count)
                            begin
                                if (b == nmea_pkg::CH_COMMA)
                                begin
                                    if (field_num_reg == 5'd0)
                                    begin
                                        if (is_gga)
                                        begin
                                            kind_next = nmea_pkg::KIND_GGA;
                                        end
                                        else if (is_rmc)
                                        begin
                                            kind_next = nmea_pkg::KIND_RMC;
                                        end
                                        else
                                        begin
                                            first_err_next = nmea_pkg::ERR_UNKNOWN;
                                        end
                                    end
                                    field_num_next = field_num_reg + 5'd1;
                                    char_cnt_next = 4'd0;
                                end
                                else if (char_cnt_reg >= lim)
                                begin
                                    first_err_next = nmea_pkg::ERR_FIELD_LONG;
                                end
                                else
                                begin
                                    if (field_num_reg == 5'd0
                                        && char_cnt_reg < 4'(nmea_pkg::TYPE_CHARS))
                                    begin
                                        type_next[char_cnt_reg[2:0]] = b;
                                    end
                                    if (char_cnt_reg == 4'd0
                                        && ((kind_reg == nmea_pkg::KIND_GGA
                                             && fid == nmea_pkg::FID_FIXQ)
                                            || (kind_reg == nmea_pkg::KIND_RMC
                                                && fid == nmea_pkg::FID_STATUS)))
                                    begin
                                        fix_char_next = b;
                                    end
                                    emit = 1'b1;
                                    char_cnt_next = char_cnt_reg + 4'd1;
                                end
                            end
                        end
                    end
                    nmea_pkg::PH_HEX:
                    begin
                        if (hex_seen_reg == 2'd0)
                        begin
                            if (b != nmea_pkg::hex_char(xor_reg[7:4]))
                            begin
                                csum_ok_next = 1'b0;
                            end
                            hex_seen_next = 2'd1;
                        end
                        else if (hex_seen_reg == 2'd1)
                        begin
                            if (b != nmea_pkg::hex_char(xor_reg[3:0]))
                            begin
                                csum_ok_next = 1'b0;
                            end
                            hex_seen_next = 2'd2;
                        end
                        else
                        begin
                            phase_next = nmea_pkg::PH_TAIL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // verdict from the state after this byte
        case (phase_next)
            nmea_pkg::PH_SKIP: code = nmea_pkg::ERR_NO_DOLLAR;
            nmea_pkg::PH_LONG: code = nmea_pkg::ERR_FIELD_LONG;
            nmea_pkg::PH_FIELDS: code = nmea_pkg::ERR_NO_STAR;
            nmea_pkg::PH_HEX: code = nmea_pkg::ERR_TRUNCATED;
            nmea_pkg::PH_TAIL:
            begin
                if (!csum_ok_next)
                begin
                    code = nmea_pkg::ERR_CHECKSUM;
                end
                else if (first_err_next != nmea_pkg::ERR_OK)
                begin
                    code = first_err_next;
                end
                else if (kind_next == nmea_pkg::KIND_NONE
                         || field_num_next < ((kind_next == nmea_pkg::KIND_RMC)
                                              ? nmea_pkg::RMC_COUNT : nmea_pkg::GGA_COUNT))
                begin
                    code = nmea_pkg::ERR_MISSING;
                end
                else
                begin
                    code = nmea_pkg::ERR_OK;
                end
            end
            default: code = nmea_pkg::ERR_NO_DOLLAR;
        endcase

        if (code == nmea_pkg::ERR_OK)
        begin
            fix = (kind_next == nmea_pkg::KIND_GGA) ? (fix_char_next > nmea_pkg::CH_ZERO)
                                                     : (fix_char_next == nmea_pkg::CH_A);
        end

        // output register
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_user_next = out_user_reg;
        out_data_next = out_data_reg;
        if (accept)
        begin
            out_valid_next = emit || s_axis_tlast;
            if (s_axis_tlast)
            begin
                out_user_next = 1'b1;
                out_data_next = {1'b0, fix, kind_next, code, 8'd0, 4'd0, 5'd0};
            end
            else
            begin
                out_user_next = 1'b0;
                out_data_next = {1'b0, 1'b0, 2'd0, 3'd0, b, char_cnt_reg, fid};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nmea_pkg::PH_IDLE;
            xor_reg <= 8'd0;
            field_num_reg <= 5'd0;
            char_cnt_reg <= 4'd0;
            for (int k = 0; k < nmea_pkg::TYPE_CHARS; k++)
            begin
                type_reg[k] <= 8'd0;
            end
            kind_reg <= nmea_pkg::KIND_NONE;
            first_err_reg <= nmea_pkg::ERR_OK;
            fix_char_reg <= nmea_pkg::CH_COMMA;
            hex_seen_reg <= 2'd0;
            csum_ok_reg <= 1'b1;
            byte_cnt_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                if (s_axis_tlast)
                begin
                    // sentence done, back to reset values
                    phase_reg <= nmea_pkg::PH_IDLE;
                    xor_reg <= 8'd0;
                    field_num_reg <= 5'd0;
                    char_cnt_reg <= 4'd0;
                    for (int k = 0; k < nmea_pkg::TYPE_CHARS; k++)
                    begin
                        type_reg[k] <= 8'd0;
                    end
                    kind_reg <= nmea_pkg::KIND_NONE;
                    first_err_reg <= nmea_pkg::ERR_OK;
                    fix_char_reg <= nmea_pkg::CH_COMMA;
                    hex_seen_reg <= 2'd0;
                    csum_ok_reg <= 1'b1;
                    byte_cnt_reg <= 8'd0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    xor_reg <= xor_next;
                    field_num_reg <= field_num_next;
                    char_cnt_reg <= char_cnt_next;
                    for (int k = 0; k < nmea_pkg::TYPE_CHARS; k++)
                    begin
                        type_reg[k] <= type_next[k];
                    end
                    kind_reg <= kind_next;
                    first_err_reg <= first_err_next;
                    fix_char_reg <= fix_char_next;
                    hex_seen_reg <= hex_seen_next;
                    csum_ok_reg <= csum_ok_next;
                    byte_cnt_reg <= byte_cnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_user_reg <= out_user_next;
        out_data_reg <= out_data_next;
    end

endmodule

[tb/sv/nmea_sentence_parser_top_tb.sv]
`timescale 1ns / 1ps

module nmea_sentence_parser_top_tb;
    import nmea_pkg::*;

    localparam int unsigned LINE_LIMIT = MAX_LEN_DEF;
    localparam int ITEM_GOAL = 450;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 2000;

    // per-field tables, field 0 in the lowest nibble or five-bit entry
    localparam logic [12:0][3:0] GGA_LIMIT =
        {4'd2, 4'd8, 4'd2, 4'd8, 4'd6, 4'd3, 4'd2, 4'd2, 4'd11, 4'd2, 4'd10, 4'd11, 4'd6};
    localparam logic [12:0][4:0] GGA_FID =
        {5'd13, 5'd12, 5'd11, 5'd10, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd4, 5'd3, 5'd1, 5'd0};
    localparam logic [9:0][3:0] RMC_LIMIT =
        {4'd8, 4'd8, 4'd8, 4'd2, 4'd11, 4'd2, 4'd10, 4'd2, 4'd11, 4'd6};
    localparam logic [9:0][4:0] RMC_FID =
        {5'd16, 5'd15, 5'd14, 5'd6, 5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0};

    typedef logic [7:0] octet_t;

    typedef struct packed {
        logic       is_verdict;
        logic [4:0] fid;
        logic [3:0] pos;
        logic [7:0] chr;
        logic [2:0] err;
        logic [1:0] kind;
        logic       fix;
    } parse_word_t;

    typedef enum int {
        FL_NONE, FL_NO_DOLLAR, FL_NO_STAR, FL_TRUNC, FL_BAD_SUM, FL_LOWER_HEX,
        FL_LONG_FIELD, FL_BAD_TYPE, FL_FEW_FIELDS, FL_EXTRA, FL_NOISE, FL_OVERLONG
    } flaw_t;

    function automatic octet_t nibble_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
    endfunction

    class nmea_scoreboard;
        parse_word_t awaited[$];
        int unsigned mismatches;
        int unsigned max_len;
        phase_t phase;
        logic [7:0] xsum;
        logic [7:0] nbytes;
        logic [7:0] fixc;
        logic [4:0] fnum;
        logic [3:0] ccount;
        logic [7:0] tchars [TYPE_CHARS];
        logic [1:0] kind;
        logic [2:0] ferr;
        logic [1:0] hexseen;
        logic csum_ok;

        function new(int unsigned limit);
            max_len = limit;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_IDLE;
            xsum = 8'd0;
            nbytes = 8'd0;
            fixc = CH_COMMA;
            fnum = 5'd0;
            ccount = 4'd0;
            foreach (tchars[k]) tchars[k] = 8'd0;
            kind = KIND_NONE;
            ferr = ERR_OK;
            hexseen = 2'd0;
            csum_ok = 1'b1;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // one text byte before the star; returns 1 when it becomes a field character
        function logic take_char(input logic [7:0] b, output logic [4:0] fid,
                                 output logic [3:0] pos);
            logic [4:0] total;
            logic [3:0] lim;
            logic [39:0] tword;
            total = (kind == KIND_RMC) ? RMC_COUNT : GGA_COUNT;
            fid = 5'd0;
            pos = 4'd0;
            if (ferr != ERR_OK || fnum >= total)
                return 1'b0;
            lim = (kind == KIND_RMC) ? RMC_LIMIT[fnum] : GGA_LIMIT[fnum];
            if (b == CH_COMMA)
            begin
                if (fnum == 5'd0)
                begin
                    tword = {tchars[0], tchars[1], tchars[2], tchars[3], tchars[4]};
                    if (ccount >= TYPE_CHARS && tword == GGA_NAME)
                        kind = KIND_GGA;
                    else if (ccount >= TYPE_CHARS && tword == RMC_NAME)
                        kind = KIND_RMC;
                    else
                        ferr = ERR_UNKNOWN;
                end
                fnum = fnum + 5'd1;
                ccount = 4'd0;
                return 1'b0;
            end
            if (ccount >= lim)
            begin
                ferr = ERR_FIELD_LONG;
                return 1'b0;
            end
            fid = (kind == KIND_RMC) ? RMC_FID[fnum] : GGA_FID[fnum];
            if (fnum == 5'd0 && ccount < TYPE_CHARS)
                tchars[ccount] = b;
            if (ccount == 4'd0 && ((kind == KIND_GGA && fid == FID_FIXQ) ||
                                   (kind == KIND_RMC && fid == FID_STATUS)))
                fixc = b;
            pos = ccount;
            ccount = ccount + 4'd1;
            return 1'b1;
        endfunction

        function logic [2:0] verdict_code();
            logic [4:0] total;
            total = (kind == KIND_RMC) ? RMC_COUNT : GGA_COUNT;
            case (phase)
                PH_SKIP:   return ERR_NO_DOLLAR;
                PH_LONG:   return ERR_FIELD_LONG;
                PH_FIELDS: return ERR_NO_STAR;
                PH_HEX:    return ERR_TRUNCATED;
                PH_TAIL:
                begin
                    if (!csum_ok) return ERR_CHECKSUM;
                    if (ferr != ERR_OK) return ferr;
                    if (kind == KIND_NONE || fnum < total) return ERR_MISSING;
                    return ERR_OK;
                end
                default:   return ERR_NO_DOLLAR;
            endcase
        endfunction

        function void note_byte(input logic [7:0] b, input logic last);
            parse_word_t w;
            logic emit;
            logic [4:0] fid;
            logic [3:0] pos;
            emit = 1'b0;
            fid = 5'd0;
            pos = 4'd0;
            if (phase == PH_IDLE)
            begin
                restart();
                nbytes = 8'd1;
                phase = (b == CH_DOLLAR) ? PH_FIELDS : PH_SKIP;
            end
            else if (phase != PH_SKIP && phase != PH_LONG)
            begin
                if (nbytes >= max_len)
                    phase = PH_LONG;
                else
                begin
                    nbytes = nbytes + 8'd1;
                    if (phase == PH_FIELDS)
                    begin
                        if (b == CH_STAR)
                        begin
                            phase = PH_HEX;
                            hexseen = 2'd0;
                        end
                        else
                        begin
                            xsum = xsum ^ b;
                            emit = take_char(b, fid, pos);
                        end
                    end
                    else if (phase == PH_HEX)
                    begin
                        if (hexseen == 2'd0)
                        begin
                            if (b != nibble_char(xsum[7:4])) csum_ok = 1'b0;
                            hexseen = 2'd1;
                        end
                        else if (hexseen == 2'd1)
                        begin
                            if (b != nibble_char(xsum[3:0])) csum_ok = 1'b0;
                            hexseen = 2'd2;
                        end
                        else
                            phase = PH_TAIL;
                    end
                end
            end
            w = '0;
            if (last)
            begin
                w.is_verdict = 1'b1;
                w.err = verdict_code();
                w.kind = kind;
                if (w.err == ERR_OK)
                    w.fix = (kind == KIND_GGA) ? (fixc > CH_ZERO) : (fixc == CH_A);
                awaited.push_back(w);
                restart();
            end
            else if (emit)
            begin
                w.fid = fid;
                w.pos = pos;
                w.chr = b;
                awaited.push_back(w);
            end
        endfunction

        function void compare_field(input string what, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(input logic tuser, input logic [23:0] data);
            parse_word_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none, got tuser %b tdata %h",
                         $time, tuser, data);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("result_type", want.is_verdict, tuser);
            compare_field("field_id", want.fid, data[4:0]);
            compare_field("char_position", want.pos, data[8:5]);
            compare_field("char_value", want.chr, data[16:9]);
            compare_field("error_code", want.err, data[19:17]);
            compare_field("sentence_kind", want.kind, data[21:20]);
            compare_field("fix_valid", want.fix, data[22]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    nmea_scoreboard sb;
    octet_t line_q[$];
    bit tx_burst;
    bit rx_free;
    bit rx_hold_req;
    int rx_wait;
    int idle_cycles;

    nmea_sentence_parser_top #(
        .MAX_LEN(LINE_LIMIT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic octet_t pick_char(input bit wild);
        string glyphs;
        octet_t c;
        glyphs = "0123456789.NSEWAVM-";
        if (!wild)
            return glyphs[$urandom_range(0, glyphs.len() - 1)];
        do
            c = $urandom_range(0, 255);
        while (c == CH_COMMA || c == CH_STAR);
        return c;
    endfunction

    function automatic flaw_t pick_flaw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return FL_NONE;
        if (r < 47) return FL_OVERLONG;
        return flaw_t'($urandom_range(FL_NO_DOLLAR, FL_NOISE));
    endfunction

    task automatic build_line(input flaw_t flaw);
        octet_t body[$];
        octet_t sum;
        octet_t hi;
        octet_t lo;
        octet_t lead;
        bit rmc;
        bit wild;
        int i;
        int k;
        int fields;
        int fix_at;
        int long_at;
        int lim;
        int len;
        int goal;
        int star_at;
        string tname;
        line_q.delete();
        rmc = $urandom_range(0, 1);
        wild = ($urandom_range(0, 3) == 0);
        if (flaw == FL_NOISE)
        begin
            repeat ($urandom_range(1, 12)) line_q.push_back($urandom_range(0, 255));
            return;
        end
        tname = rmc ? "GPRMC" : "GPGGA";
        if (flaw == FL_BAD_TYPE)
        begin
            case ($urandom_range(0, 3))
                0: tname = rmc ? "GPRM" : "GPGG";
                1: tname = "GPGSV";
                2: tname = rmc ? "gprmc" : "gpgga";
                default: tname = "";
            endcase
        end
        else if ($urandom_range(0, 4) == 0)
            tname = {tname, "X"};
        for (i = 0; i < tname.len(); i++) body.push_back(tname[i]);
        fields = rmc ? RMC_COUNT : GGA_COUNT;
        fix_at = rmc ? 2 : 6;
        long_at = (flaw == FL_LONG_FIELD) ? $urandom_range(0, fields - 1) : -1;
        if (long_at == 0)
            repeat (7 - tname.len() + $urandom_range(0, 2)) body.push_back(pick_char(wild));
        if (flaw == FL_FEW_FIELDS) fields = $urandom_range(1, fields - 1);
        for (i = 1; i < fields; i++)
        begin
            body.push_back(CH_COMMA);
            lim = rmc ? RMC_LIMIT[i] : GGA_LIMIT[i];
            if (i == long_at)
                len = lim + $urandom_range(1, 3);
            else if ($urandom_range(0, 1))
                len = $urandom_range(0, 2);
            else
                len = $urandom_range(0, lim);
            for (k = 0; k < len; k++)
            begin
                if (i == fix_at && k == 0)
                    body.push_back(pick_char(0) | (($urandom_range(0, 1)) ? 8'h00 : 8'h00));
                else
                    body.push_back(pick_char(wild));
            end
        end
        // the closing comma completes the last field
        if (flaw != FL_FEW_FIELDS || $urandom_range(0, 1)) body.push_back(CH_COMMA);
        if (flaw == FL_EXTRA)
            repeat ($urandom_range(1, 4))
            begin
                repeat ($urandom_range(0, 3)) body.push_back(pick_char(wild));
                body.push_back(CH_COMMA);
            end
        if (flaw == FL_OVERLONG)
        begin
            case ($urandom_range(0, 3))
                0: goal = 254;
                1: goal = 255;
                2: goal = 256;
                default: goal = $urandom_range(257, 300);
            endcase
            repeat (goal - (body.size() + 6)) body.push_back(pick_char(wild));
        end
        sum = 8'd0;
        foreach (body[k]) sum = sum ^ body[k];
        if (flaw == FL_BAD_SUM) sum = sum ^ octet_t'($urandom_range(1, 255));
        hi = nibble_char(sum[7:4]);
        lo = nibble_char(sum[3:0]);
        if (flaw == FL_LOWER_HEX)
        begin
            if (hi > 8'h39) hi = hi | 8'h20;
            if (lo > 8'h39) lo = lo | 8'h20;
        end
        lead = CH_DOLLAR;
        if (flaw == FL_NO_DOLLAR)
            do
                lead = $urandom_range(0, 255);
            while (lead == CH_DOLLAR);
        line_q.push_back(lead);
        foreach (body[k]) line_q.push_back(body[k]);
        star_at = line_q.size();
        if (flaw != FL_NO_STAR)
        begin
            line_q.push_back(CH_STAR);
            line_q.push_back(hi);
            line_q.push_back(lo);
        end
        if ($urandom_range(0, 1)) line_q.push_back(8'h0D);
        line_q.push_back(8'h0A);
        if (flaw == FL_TRUNC)
        begin
            k = $urandom_range(0, 3) == 0 ? $urandom_range(0, star_at - 1)
                                          : star_at + $urandom_range(0, 2);
            line_q = line_q[0:k];
        end
    endtask

    task automatic send_line();
        int i;
        int gap;
        for (i = 0; i < line_q.size(); i++)
        begin
            gap = tx_burst ? 0 : pick_gap();
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= line_q[i];
            s_axis_tlast <= (i == line_q.size() - 1);
            do
                @(posedge clk);
            while (!s_axis_tready);
            sb.note_byte(line_q[i], i == line_q.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        line_q.delete();
        for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
        send_line();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        rx_wait = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_wait = HOLD_CYCLES;
            end
            if (rx_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_free && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tuser, m_axis_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int weight;
        flaw_t flaw;
        idle_cycles = 0;
        tx_burst = 1'b0;
        rx_free = 1'b0;
        rx_hold_req = 1'b0;
        sb = new(LINE_LIMIT);
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'd0;
        s_axis_tlast <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short sentences: no dollar, no star, truncated, fields missing,
        // unknown type, lowercase checksum digits, a lone all-ones byte
        send_text("X");
        send_text("$");
        send_text("$G*");
        send_text("$*00\n");
        send_text("$A,*6D\r\n");
        send_text("$Z*5a\n");
        line_q.delete();
        line_q.push_back(8'hFF);
        send_line();

        weight = 0;
        for (n = 0; weight < ITEM_GOAL; n++)
        begin
            flaw = (n <= FL_OVERLONG) ? flaw_t'(n) : pick_flaw();
            build_line(flaw);
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_free = ($urandom_range(0, 4) == 0);
            if (n == 0)
            begin
                // receiver holds off while the sender keeps offering words
                tx_burst = 1'b1;
                rx_free = 1'b0;
                rx_hold_req = 1'b1;
            end
            if (n == 6 || n == 17) wait_drained();
            send_line();
            weight += line_q.size();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
